FILE: src/tse_pkg.sv
// Package for the topological sort engine: sizes, request and status codes.
// No dependencies.
package tse_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 16384;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = EADDR_W + 1;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_SORT  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ORDER    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_INDEX    = 3'd4;
endpackage

FILE: src/topological_sort_engine.sv
// Kahn topological sort engine over four synchronous one-write, one-read-port memories.
// Depends on tse_pkg.
//
// channel   direction  handshake               payload
// request   in         start & !busy           req_type, src_node, dst_node, order_index
// result    out        done, one cycle         order_node, sorted_count, has_cycle, status
// config    in         cfg_valid & cfg_ready   cfg_data (node_count)
//
// Clear and failed items finish in IDLE. Read goes via S_RDV. Edge fills row_start gaps.
// Sort fills row_start for nodes opened late, clears and counts in-degrees, queues
// zero-degree nodes and walks each queued node's edges by read-modify-write.
// Reset clears control registers only; memories hold nothing until written.
// The receiver cannot stall; busy holds off new items during a run.
module topological_sort_engine import tse_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [NODE_W-1:0]  src_node,
  input  logic [NODE_W-1:0]  dst_node,
  input  logic [NODE_W-1:0]  order_index,
  output logic               done,
  output logic [NODE_W-1:0]  order_node,
  output logic [CNT_W-1:0]   sorted_count,
  output logic               has_cycle,
  output logic [2:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1 << 0,
    S_EFILL = 19'd1 << 1,
    S_SFILL = 19'd1 << 2,
    S_SEND  = 19'd1 << 3,
    S_SCLR  = 19'd1 << 4,
    S_CRD   = 19'd1 << 5,
    S_CDEG  = 19'd1 << 6,
    S_CWR   = 19'd1 << 7,
    S_ZRD   = 19'd1 << 8,
    S_ZCHK  = 19'd1 << 9,
    S_QRD   = 19'd1 << 10,
    S_RLO   = 19'd1 << 11,
    S_RHI   = 19'd1 << 12,
    S_RWAIT = 19'd1 << 13,
    S_JRD   = 19'd1 << 14,
    S_JDEG  = 19'd1 << 15,
    S_JWR   = 19'd1 << 16,
    S_RDV   = 19'd1 << 17,
    S_SPARE = 19'd1 << 18
  } state_t;

  state_t state;

  logic [ECNT_W-1:0] row_start [0:MAX_NODES];
  logic [NODE_W-1:0] edge_target [0:MAX_EDGES-1];
  logic [ECNT_W-1:0] in_degree [0:MAX_NODES-1];
  logic [NODE_W-1:0] order_queue [0:MAX_NODES-1];

  logic [CNT_W-1:0]   node_count;
  logic [ECNT_W-1:0]  edge_total;
  logic [CNT_W-1:0]   last_source;
  logic [CNT_W-1:0]   placed_total;
  logic               cycle_flag;
  logic [CNT_W-1:0]   k;
  logic [ECNT_W-1:0]  e;
  logic [ECNT_W-1:0]  edge_end;
  logic [ECNT_W-1:0]  j;
  logic [ECNT_W-1:0]  hi;
  logic [CNT_W-1:0]   tail;
  logic [CNT_W-1:0]   head;
  logic [NODE_W-1:0]  u;
  logic [NODE_W-1:0]  t;
  logic [NODE_W-1:0]  src;
  logic [NODE_W-1:0]  dst;

  logic               rs_we;
  logic [CNT_W-1:0]   rs_waddr;
  logic [CNT_W-1:0]   rs_raddr;
  logic [ECNT_W-1:0]  rs_rdata;
  logic               et_we;
  logic [EADDR_W-1:0] et_raddr;
  logic [NODE_W-1:0]  et_rdata;
  logic               dg_we;
  logic [NODE_W-1:0]  dg_waddr;
  logic [ECNT_W-1:0]  dg_wdata;
  logic [NODE_W-1:0]  dg_raddr;
  logic [ECNT_W-1:0]  dg_rdata;
  logic               oq_we;
  logic [NODE_W-1:0]  oq_waddr;
  logic [NODE_W-1:0]  oq_wdata;
  logic [NODE_W-1:0]  oq_raddr;
  logic [NODE_W-1:0]  oq_rdata;

  logic [CNT_W-1:0]   src_inc;
  logic [CNT_W-1:0]   cfg_clamped;
  logic [ECNT_W-1:0]  dg_dec;

  assign busy      = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign src_inc   = {1'b0, src} + CNT_W'(1);
  assign dg_dec    = dg_rdata - ECNT_W'(1);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(MAX_NODES)) begin
      cfg_clamped = CNT_W'(MAX_NODES);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_comb begin
    rs_we    = 1'b0;
    rs_waddr = k;
    rs_raddr = node_count;
    et_we    = 1'b0;
    et_raddr = e[EADDR_W-1:0];
    dg_we    = 1'b0;
    dg_waddr = t;
    dg_wdata = '0;
    dg_raddr = t;
    oq_we    = 1'b0;
    oq_waddr = tail[NODE_W-1:0];
    oq_wdata = t;
    oq_raddr = head[NODE_W-1:0];
    unique case (state)
      S_IDLE: begin
        oq_raddr = order_index;
      end
      S_EFILL: begin
        if (k <= {1'b0, src}) begin
          rs_we = 1'b1;
        end else begin
          et_we = 1'b1;
        end
      end
      S_SFILL: begin
        if (k <= node_count) begin
          rs_we = 1'b1;
        end
      end
      S_SCLR: begin
        if (k < node_count) begin
          dg_we    = 1'b1;
          dg_waddr = k[NODE_W-1:0];
        end
      end
      S_CDEG: begin
        dg_raddr = et_rdata;
      end
      S_CWR: begin
        dg_we    = 1'b1;
        dg_wdata = dg_rdata + ECNT_W'(1);
      end
      S_ZRD: begin
        dg_raddr = k[NODE_W-1:0];
      end
      S_ZCHK: begin
        if (dg_rdata == '0) begin
          oq_we    = 1'b1;
          oq_wdata = k[NODE_W-1:0];
        end
      end
      S_RLO: begin
        rs_raddr = {1'b0, oq_rdata};
      end
      S_RHI: begin
        rs_raddr = {1'b0, u} + CNT_W'(1);
      end
      S_JRD: begin
        et_raddr = j[EADDR_W-1:0];
      end
      S_JDEG: begin
        dg_raddr = et_rdata;
      end
      S_JWR: begin
        if (dg_rdata != '0) begin
          dg_we    = 1'b1;
          dg_wdata = dg_dec;
          if (dg_dec == '0 && tail < CNT_W'(MAX_NODES)) begin
            oq_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      row_start[rs_waddr] <= edge_total;
    end
    rs_rdata <= row_start[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (et_we) begin
      edge_target[edge_total[EADDR_W-1:0]] <= dst;
    end
    et_rdata <= edge_target[et_raddr];
  end

  always_ff @(posedge clk) begin
    if (dg_we) begin
      in_degree[dg_waddr] <= dg_wdata;
    end
    dg_rdata <= in_degree[dg_raddr];
  end

  always_ff @(posedge clk) begin
    if (oq_we) begin
      order_queue[oq_waddr] <= oq_wdata;
    end
    oq_rdata <= order_queue[oq_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      node_count   <= CNT_W'(MAX_NODES);
      edge_total   <= '0;
      last_source  <= '0;
      placed_total <= '0;
      cycle_flag   <= 1'b0;
      tail         <= '0;
      head         <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_clamped;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            src <= src_node;
            dst <= dst_node;
            case (req_type)
              REQ_CLEAR: begin
                edge_total   <= '0;
                last_source  <= '0;
                placed_total <= '0;
                cycle_flag   <= 1'b0;
                done         <= 1'b1;
                order_node   <= '0;
                sorted_count <= '0;
                has_cycle    <= 1'b0;
                status       <= ST_OK;
              end
              REQ_EDGE: begin
                order_node   <= '0;
                sorted_count <= placed_total;
                has_cycle    <= cycle_flag;
                if ({1'b0, src_node} >= node_count || {1'b0, dst_node} >= node_count) begin
                  done   <= 1'b1;
                  status <= ST_RANGE;
                end else if ({1'b0, src_node} + CNT_W'(1) < last_source) begin
                  done   <= 1'b1;
                  status <= ST_ORDER;
                end else if (edge_total >= ECNT_W'(MAX_EDGES)) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  k     <= last_source;
                  state <= S_EFILL;
                end
              end
              REQ_SORT: begin
                k     <= last_source;
                state <= S_SFILL;
              end
              default: begin
                sorted_count <= placed_total;
                has_cycle    <= cycle_flag;
                if ({1'b0, order_index} < placed_total) begin
                  state <= S_RDV;
                end else begin
                  done       <= 1'b1;
                  order_node <= '0;
                  status     <= ST_INDEX;
                end
              end
            endcase
          end
        end
        S_EFILL: begin
          if (k <= {1'b0, src}) begin
            k <= k + CNT_W'(1);
          end else begin
            edge_total <= edge_total + ECNT_W'(1);
            if (last_source < src_inc) begin
              last_source <= src_inc;
            end
            done   <= 1'b1;
            status <= ST_OK;
            state  <= S_IDLE;
          end
        end
        S_SFILL: begin
          if (k <= node_count) begin
            k <= k + CNT_W'(1);
          end else begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          edge_end <= rs_rdata;
          k        <= '0;
          state    <= S_SCLR;
        end
        S_SCLR: begin
          if (k < node_count) begin
            k <= k + CNT_W'(1);
          end else begin
            e     <= '0;
            state <= S_CRD;
          end
        end
        S_CRD: begin
          if (e < edge_end) begin
            state <= S_CDEG;
          end else begin
            k     <= '0;
            tail  <= '0;
            state <= S_ZRD;
          end
        end
        S_CDEG: begin
          t <= et_rdata;
          if ({1'b0, et_rdata} < node_count) begin
            state <= S_CWR;
          end else begin
            e     <= e + ECNT_W'(1);
            state <= S_CRD;
          end
        end
        S_CWR: begin
          e     <= e + ECNT_W'(1);
          state <= S_CRD;
        end
        S_ZRD: begin
          if (k < node_count) begin
            state <= S_ZCHK;
          end else begin
            head  <= '0;
            state <= S_QRD;
          end
        end
        S_ZCHK: begin
          if (dg_rdata == '0) begin
            tail <= tail + CNT_W'(1);
          end
          k     <= k + CNT_W'(1);
          state <= S_ZRD;
        end
        S_QRD: begin
          if (head < tail) begin
            state <= S_RLO;
          end else begin
            placed_total <= tail;
            cycle_flag   <= (tail < node_count);
            done         <= 1'b1;
            order_node   <= '0;
            sorted_count <= tail;
            has_cycle    <= (tail < node_count);
            status       <= ST_OK;
            state        <= S_IDLE;
          end
        end
        S_RLO: begin
          u     <= oq_rdata;
          head  <= head + CNT_W'(1);
          state <= S_RHI;
        end
        S_RHI: begin
          j     <= rs_rdata;
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          hi    <= rs_rdata;
          state <= S_JRD;
        end
        S_JRD: begin
          if (j < hi) begin
            state <= S_JDEG;
          end else begin
            state <= S_QRD;
          end
        end
        S_JDEG: begin
          t <= et_rdata;
          if ({1'b0, et_rdata} < node_count) begin
            state <= S_JWR;
          end else begin
            j     <= j + ECNT_W'(1);
            state <= S_JRD;
          end
        end
        S_JWR: begin
          if (dg_rdata != '0 && dg_dec == '0 && tail < CNT_W'(MAX_NODES)) begin
            tail <= tail + CNT_W'(1);
          end
          j     <= j + ECNT_W'(1);
          state <= S_JRD;
        end
        S_RDV: begin
          done       <= 1'b1;
          order_node <= oq_rdata;
          status     <= ST_OK;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= CNT_W'(MAX_NODES)) else $error("queue tail beyond capacity");
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_RLO) |-> head < tail) else $error("queue read past tail");
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= ECNT_W'(MAX_EDGES)) else $error("edge store overrun");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_IDLE) || $past(busy)) else $error("stray result");
`endif

endmodule
